### sv/pcq_pkg.sv
// Package for the pitch CV scale quantizer: field widths, per-voice state
// layout, register indexes, the scale tables and the snap function.
// No dependencies.
package pcq_pkg;

    localparam int VOICES    = 16;
    localparam int VOICE_AW  = $clog2(VOICES);
    localparam int VOICE_W   = 4;
    localparam int SAMPLE_W  = 16;
    localparam int NOTE_W    = 11;
    localparam int PULSE_W   = 10;
    localparam int THRESH_W  = 15;
    localparam int SCALE_W   = 4;
    localparam int PITCH_W   = 12;
    localparam int TR_W      = 8;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 15;
    localparam int IN_DW     = 56;
    localparam int OUT_DW    = 24;
    localparam int NUM_SCALES = 11;

    // 1200 + floor(pitch / 256) always lands in 1072..1327
    localparam logic [NOTE_W-1:0] RAW_BASE    = NOTE_W'(1072);
    localparam logic [NOTE_W-1:0] NOTE_OFFSET = NOTE_W'(1200);
    // floor(n * RECIP_12 / 2^15) == floor(n / 12) for every 11-bit n
    localparam logic [11:0] RECIP_12 = 12'd2731;
    localparam int RECIP_SH = 15;

    localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(2048);
    localparam logic [PULSE_W-1:0]  PULSE_RST  = PULSE_W'(512);

    typedef enum logic [CFG_AW-1:0] {
        CFG_SCALE  = 2'd0,
        CFG_MODE   = 2'd1,
        CFG_THRESH = 2'd2,
        CFG_PULSE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [NOTE_W-1:0]  held;
        logic [PULSE_W-1:0] count;
        logic               armed;
    } t_vstate;

    localparam int STATE_W = $bits(t_vstate);

    localparam logic [3:0] SCALE_TAB [NUM_SCALES][12] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
        '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd4, 4'd6, 4'd6, 4'd8, 4'd8, 4'd10, 4'd10},
        '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd11},
        '{4'd0, 4'd0, 4'd2, 4'd3, 4'd3, 4'd5, 4'd5, 4'd7, 4'd8, 4'd8, 4'd10, 4'd10},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd4, 4'd4, 4'd4, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7},
        '{4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd4, 4'd4, 4'd4, 4'd7, 4'd7, 4'd7, 4'd7, 4'd11},
        '{4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3, 4'd7, 4'd7, 4'd7, 4'd10, 4'd10},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd4, 4'd4, 4'd4, 4'd7, 4'd7, 4'd9, 4'd9, 4'd9},
        '{4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3, 4'd7, 4'd7, 4'd9, 4'd9, 4'd9},
        '{4'd0, 4'd0, 4'd2, 4'd2, 4'd2, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd9}
    };

    // Snap a semitone number within its octave; unused selectors act chromatic.
    function automatic logic [NOTE_W-1:0] snap_note(input logic [NOTE_W-1:0] n,
                                                    input logic [SCALE_W-1:0] sel);
        logic [NOTE_W+11:0] prod;
        logic [7:0]         oct;
        logic [NOTE_W-1:0]  base;
        logic [3:0]         rem;
        logic [3:0]         off;
        prod = {12'd0, n} * {11'd0, RECIP_12};
        oct  = 8'(prod >> RECIP_SH);
        base = NOTE_W'({3'd0, oct} * NOTE_W'(12));
        rem  = 4'(n - base);
        if (sel < SCALE_W'(NUM_SCALES)) begin
            off = SCALE_TAB[sel][rem];
        end else begin
            off = SCALE_TAB[0][rem];
        end
        return base + NOTE_W'(off);
    endfunction

endpackage

### sv/pcq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/pitch_cv_scale_quantizer.sv
// Pitch CV scale quantizer top level: per-voice state in pcq_ram, read at
// accept, updated and written back when its update commits. Depends on pcq_pkg, pcq_ram.
//
//   channel  | direction | handshake                      | payload
//   ---------+-----------+--------------------------------+---------------------------
//   s_axis   | in        | s_axis_tvalid / s_axis_tready  | voice, pitch, level, transpose
//   m_axis   | out       | m_axis_tvalid / m_axis_tready  | voice, pitch (semitones), gate
//   cfg      | in        | i_cfg_valid / o_cfg_ready      | register index, data
//
// One item per clock sustained while the output does not stall; an item is registered in
// the update stage at accept, with the state RAM read, and in the output register at commit.
// Back-to-back items of the same voice take the just-written state from a forward register.
// Reset clears the per-voice valid bits, so all state reads as zero; no clearing pass.
// A stalled output holds the update stage; input is taken again as soon as it drains.
module pitch_cv_scale_quantizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [3:0] voice, [19:4] pitch_in, [35:20] trig_level, [51:36] transpose_in, [55:52] zero
    input  logic [pcq_pkg::IN_DW-1:0]      s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] voice_out, [15:4] pitch_out, [16] gate_out, [23:17] zero
    output logic [pcq_pkg::OUT_DW-1:0]     m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pcq_pkg::CFG_AW-1:0]     i_cfg_index,
    input  logic [pcq_pkg::CFG_DW-1:0]     i_cfg_data
);

    import pcq_pkg::*;

    // configuration
    logic [SCALE_W-1:0]  r_scale;
    logic                r_mode;
    logic [THRESH_W-1:0] r_thresh;
    logic [PULSE_W-1:0]  r_pulse_len;

    // input field decode
    logic [VOICE_W-1:0]         in_voice;
    logic signed [SAMPLE_W-1:0] in_pitch;
    logic signed [SAMPLE_W-1:0] in_level;
    logic signed [SAMPLE_W-1:0] in_transpose;
    logic [VOICE_AW-1:0]        in_slot;
    logic [NOTE_W-1:0]          in_raw;
    logic [NOTE_W-1:0]          in_qraw;
    logic signed [TR_W-1:0]     in_tr;
    logic                       in_gt;
    logic                       in_lt;
    logic                       in_accept;

    // update stage
    logic                       r_s1_vld;
    logic [VOICE_W-1:0]         r_s1_voice;
    logic [VOICE_AW-1:0]        r_s1_slot;
    logic [NOTE_W-1:0]          r_s1_raw;
    logic [NOTE_W-1:0]          r_s1_qraw;
    logic signed [TR_W-1:0]     r_s1_tr;
    logic                       r_s1_gt;
    logic                       r_s1_lt;
    logic                       r_s1_init;
    logic                       r_fwd_hit;
    t_vstate                    r_fwd_state;
    logic [VOICES-1:0]          r_init;

    logic [STATE_W-1:0]         ram_rdata;
    t_vstate                    old_state;
    t_vstate                    n_state;
    logic [NOTE_W-1:0]          held_snap;
    logic                       trig_rise;
    logic                       s1_gate;
    logic [NOTE_W-1:0]          s1_note;
    logic signed [PITCH_W:0]    s1_sum;
    logic                       s1_commit;

    // output register
    logic                       r_out_vld;
    logic [VOICE_W-1:0]         r_out_voice;
    logic [PITCH_W-1:0]         r_out_pitch;
    logic                       r_out_gate;

    assign in_voice     = s_axis_tdata[3:0];
    assign in_pitch     = s_axis_tdata[19:4];
    assign in_level     = s_axis_tdata[35:20];
    assign in_transpose = s_axis_tdata[51:36];
    assign in_slot      = VOICE_AW'(in_voice);

    // floor(pitch / 256) + 1200 from the offset-binary high byte
    assign in_raw  = RAW_BASE + NOTE_W'({~in_pitch[15], in_pitch[14:8]});
    assign in_qraw = snap_note(in_raw, r_scale);

    // truncate toward zero: floor, then bump up negatives with a remainder
    always_comb begin
        in_tr = in_transpose[15:8];
        if (in_transpose[15] && (in_transpose[7:0] != 8'd0)) begin
            in_tr = in_transpose[15:8] + TR_W'(1);
        end
    end

    assign in_gt = $signed({in_level[15], in_level}) > $signed({2'b00, r_thresh});
    assign in_lt = $signed({in_level[15], in_level}) < $signed({2'b00, r_thresh});

    assign s1_commit     = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_commit;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    pcq_ram #(
        .WIDTH (STATE_W),
        .DEPTH (VOICES)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_commit),
        .i_waddr (r_s1_slot),
        .i_wdata (n_state),
        .i_re    (in_accept),
        .i_raddr (in_slot),
        .o_rdata (ram_rdata)
    );

    // forward over the RAM when the previous item wrote this voice at our read
    always_comb begin
        if (r_fwd_hit) begin
            old_state = r_fwd_state;
        end else if (r_s1_init) begin
            old_state = t_vstate'(ram_rdata);
        end else begin
            old_state = '0;
        end
    end

    assign held_snap = snap_note(old_state.held, r_scale);
    assign trig_rise = r_mode && !old_state.armed && r_s1_gt;

    always_comb begin
        n_state = old_state;
        s1_gate = 1'b0;
        s1_note = r_s1_qraw;
        if (!r_mode) begin
            if (old_state.held != r_s1_qraw) begin
                n_state.held  = r_s1_qraw;
                n_state.count = r_pulse_len;
                s1_gate       = 1'b1;
            end else if (old_state.count != '0) begin
                n_state.count = old_state.count - PULSE_W'(1);
                s1_gate       = 1'b1;
            end
        end else begin
            if (trig_rise) begin
                n_state.armed = 1'b1;
                n_state.held  = r_s1_raw;
                n_state.count = r_pulse_len;
            end else if (old_state.armed && r_s1_lt) begin
                n_state.armed = 1'b0;
            end
            if (n_state.count != '0) begin
                n_state.count = n_state.count - PULSE_W'(1);
                s1_gate       = 1'b1;
            end
            s1_note = trig_rise ? r_s1_qraw : held_snap;
        end
    end

    assign s1_sum = $signed({2'b00, s1_note}) - $signed({2'b00, NOTE_OFFSET})
                  + (PITCH_W+1)'(r_s1_tr);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= '0;
            r_mode      <= 1'b0;
            r_thresh    <= THRESH_RST;
            r_pulse_len <= PULSE_RST;
            r_s1_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_init      <= '0;
            r_fwd_hit   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SCALE:  r_scale     <= SCALE_W'(i_cfg_data);
                    CFG_MODE:   r_mode      <= i_cfg_data[0];
                    CFG_THRESH: r_thresh    <= THRESH_W'(i_cfg_data);
                    CFG_PULSE:  r_pulse_len <= PULSE_W'(i_cfg_data);
                endcase
            end
            if (in_accept) begin
                r_s1_vld  <= 1'b1;
                r_fwd_hit <= s1_commit && (in_slot == r_s1_slot);
            end else if (s1_commit) begin
                r_s1_vld  <= 1'b0;
            end
            if (s1_commit) begin
                r_init[r_s1_slot] <= 1'b1;
                r_out_vld         <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_voice  <= in_voice;
            r_s1_slot   <= in_slot;
            r_s1_raw    <= in_raw;
            r_s1_qraw   <= in_qraw;
            r_s1_tr     <= in_tr;
            r_s1_gt     <= in_gt;
            r_s1_lt     <= in_lt;
            r_s1_init   <= r_init[in_slot];
            r_fwd_state <= n_state;
        end
        if (s1_commit) begin
            r_out_voice <= r_s1_voice;
            r_out_pitch <= s1_sum[PITCH_W-1:0];
            r_out_gate  <= s1_gate;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out_gate, r_out_pitch, r_out_voice};

endmodule

### sim/pcq_checker.sv
// Scoreboard for the pitch CV scale quantizer: watches the sample, result and
// register channels, predicts each result from its own per-voice state and
// compares it field by field. Depends on pcq_pkg.
module pcq_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [pcq_pkg::IN_DW-1:0]  i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [pcq_pkg::OUT_DW-1:0] i_out_data,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [pcq_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [pcq_pkg::CFG_DW-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_mismatches
);
    import pcq_pkg::*;

    localparam int NUM_VOICES = 16;
    localparam int PRINT_MAX  = 40;

    typedef struct packed {
        logic [3:0]  voice;
        logic [11:0] pitch;
        logic        gate;
    } t_note_out;

    // register copies
    logic [3:0] scale_sel;
    logic       hold_mode;
    int         threshold;
    int         pulse_len;

    // per-voice state
    int held_note [NUM_VOICES];
    int gate_left [NUM_VOICES];
    bit armed     [NUM_VOICES];

    t_note_out pending_notes [$];
    t_note_out want;
    t_note_out got;

    // Scale degrees packed one nibble per step, step 0 in the low nibble.
    function automatic logic [47:0] degree_row(input logic [3:0] sel);
        case (sel)
            4'd1:    return 48'hAA8866442200;
            4'd2:    return 48'hB99775542200;
            4'd3:    return 48'hAA8875533200;
            4'd4:    return 48'h777774440000;
            4'd5:    return 48'h777773333000;
            4'd6:    return 48'hB77774440000;
            4'd7:    return 48'hAA7773333000;
            4'd8:    return 48'h999774440000;
            4'd9:    return 48'h999773333000;
            4'd10:   return 48'h999775522200;
            default: return 48'hBA9876543210;
        endcase
    endfunction

    function automatic int snap_in_scale(input int n, input logic [3:0] sel);
        logic [47:0] row;
        row = degree_row(sel);
        return (n / 12) * 12 + int'(row[(n % 12) * 4 +: 4]);
    endfunction

    function automatic t_note_out quantize_sample(input logic [IN_DW-1:0] d);
        t_note_out  r;
        logic [3:0] v;
        int         pitch;
        int         level;
        int         shift;
        int         raw;
        int         q;
        int         note;
        logic       gate;
        v     = d[3:0];
        pitch = int'($signed(d[19:4]));
        level = int'($signed(d[35:20]));
        shift = int'($signed(d[51:36]));
        shift = shift / 256;
        // 1200 + floor(pitch / 256)
        raw = (pitch + 32768) / 256 + 1072;
        if (!hold_mode) begin
            q = snap_in_scale(raw, scale_sel);
            if (held_note[v] != q) begin
                held_note[v] = q;
                gate_left[v] = pulse_len;
                gate = 1'b1;
            end else if (gate_left[v] > 0) begin
                gate_left[v]--;
                gate = 1'b1;
            end else begin
                gate = 1'b0;
            end
            note = held_note[v];
        end else begin
            // level equal to the threshold neither arms nor disarms
            if (!armed[v] && level > threshold) begin
                armed[v]     = 1'b1;
                held_note[v] = raw;
                gate_left[v] = pulse_len;
            end else if (armed[v] && level < threshold) begin
                armed[v] = 1'b0;
            end
            if (gate_left[v] > 0) begin
                gate_left[v]--;
                gate = 1'b1;
            end else begin
                gate = 1'b0;
            end
            note = snap_in_scale(held_note[v], scale_sel);
        end
        note    = note - 1200 + shift;
        r.voice = v;
        r.pitch = 12'(note);
        r.gate  = gate;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        if (o_mismatches < PRINT_MAX) begin
            $display("MISMATCH %s: expected %0d, got %0d (t=%0t)", what, exp_val, got_val,
                     $realtime);
        end
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scale_sel = 4'd0;
            hold_mode = 1'b0;
            threshold = 2048;
            pulse_len = 512;
            for (int k = 0; k < NUM_VOICES; k++) begin
                held_note[k] = 0;
                gate_left[k] = 0;
                armed[k]     = 1'b0;
            end
            pending_notes.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SCALE:  scale_sel = i_cfg_data[3:0];
                    CFG_MODE:   hold_mode = i_cfg_data[0];
                    CFG_THRESH: threshold = int'(i_cfg_data[14:0]);
                    CFG_PULSE:  pulse_len = int'(i_cfg_data[9:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                pending_notes.push_back(quantize_sample(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                got.voice = i_out_data[3:0];
                got.pitch = i_out_data[15:4];
                got.gate  = i_out_data[16];
                if (pending_notes.size() == 0) begin
                    report_mismatch("result with nothing pending, voice", -1,
                                    int'(got.voice));
                end else begin
                    want = pending_notes.pop_front();
                    if (got.voice != want.voice) begin
                        report_mismatch("voice_out", int'(want.voice), int'(got.voice));
                    end
                    if (got.pitch != want.pitch) begin
                        report_mismatch("pitch_out", int'($signed(want.pitch)),
                                        int'($signed(got.pitch)));
                    end
                    if (got.gate != want.gate) begin
                        report_mismatch("gate_out", int'(want.gate), int'(got.gate));
                    end
                end
            end
        end
        o_pending <= pending_notes.size();
    end

endmodule

### sim/tb_pitch_cv_scale_quantizer.sv
// Testbench top for the pitch CV scale quantizer: clock, reset, sample and
// register stimulus, output back-pressure and the verdict.
// Depends on pcq_pkg, pitch_cv_scale_quantizer and pcq_checker.
module tb_pitch_cv_scale_quantizer;
    import pcq_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASES        = 10;
    localparam int PHASE_SAMPLES = 68;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_DW-1:0]   m_axis_tdata;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_AW-1:0]   i_cfg_index;
    logic [CFG_DW-1:0]   i_cfg_data;

    int   pending;
    int   mismatches;
    bit   idle_on      = 1'b1;
    logic hold_off_req = 1'b0;
    int   samples_sent = 0;
    int   settings     = 0;
    logic mode_now     = 1'b0;
    int   thresh_now   = 2048;
    int   cur_pitch [16];

    pitch_cv_scale_quantizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pcq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done     = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= !(idle_on && $urandom_range(99) < 38);
        end
    end

    function automatic int clamp16(input int x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    task automatic send_sample(input logic [3:0] voice, input logic [15:0] pitch,
                               input logic [15:0] level, input logic [15:0] transpose);
        while (idle_on && $urandom_range(99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, transpose, level, pitch, voice};
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // Hold the input until every pending result is out, then let the pipe settle.
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Unused upper data bits carry random noise.
    task automatic set_config(input logic [3:0] scale, input logic mode,
                              input logic [14:0] thresh, input logic [9:0] plen);
        wait_drained();
        put_reg(CFG_SCALE, {11'($urandom), scale});
        put_reg(CFG_MODE, {14'($urandom), mode});
        put_reg(CFG_THRESH, thresh);
        put_reg(CFG_PULSE, {5'($urandom), plen});
        i_cfg_valid <= 1'b0;
        mode_now   = mode;
        thresh_now = int'(thresh);
        settings++;
    endtask

    // Mostly steady notes on a few voices; in trigger mode levels hover at the threshold.
    task automatic send_random_sample;
        int v;
        int lv;
        int tp;
        int pick;
        v = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(15);
        if ($urandom_range(99) < 25) begin
            if ($urandom_range(1) == 1) begin
                cur_pitch[v] = int'($signed(16'($urandom)));
            end else begin
                cur_pitch[v] = clamp16(cur_pitch[v] + int'($urandom_range(1200)) - 600);
            end
        end
        pick = $urandom_range(99);
        if (mode_now && pick < 10) begin
            lv = thresh_now;
        end else if (mode_now && pick < 70) begin
            if ($urandom_range(1) == 1) lv = thresh_now + int'($urandom_range(1, 300));
            else lv = thresh_now - int'($urandom_range(300));
        end else begin
            lv = int'($signed(16'($urandom)));
        end
        if ($urandom_range(99) < 70) tp = int'($urandom_range(1536)) - 768;
        else tp = int'($signed(16'($urandom)));
        send_sample(4'(v), 16'(cur_pitch[v]), 16'(clamp16(lv)), 16'(tp));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SCALE;
        i_cfg_data    = '0;
        for (int k = 0; k < 16; k++) cur_pitch[k] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: chromatic, free running, pitch and transpose extremes
        send_sample(4'd0, 16'h8000, 16'h0000, 16'h0000);
        send_sample(4'd0, 16'h7FFF, 16'h0000, 16'h7FFF);
        send_sample(4'd1, 16'hFFFF, 16'h7FFF, 16'h8000);
        send_sample(4'd1, 16'h0100, 16'h8000, 16'hFF01);
        send_sample(4'd2, 16'h00FF, 16'h0000, 16'h00FF);
        send_sample(4'd2, 16'h00FF, 16'h0000, 16'hFF00);
        send_sample(4'd15, 16'h0000, 16'h0000, 16'h0100);
        send_sample(4'd15, 16'h0000, 16'h0000, 16'h0000);

        // pentatonic with a pulse length of one: repeats count the gate down
        set_config(4'd10, 1'b0, 15'd2048, 10'd1);
        send_sample(4'd3, 16'h0300, 16'h0000, 16'h0000);
        send_sample(4'd3, 16'h0300, 16'h0000, 16'h0000);
        send_sample(4'd3, 16'h0300, 16'h0000, 16'h0000);
        send_sample(4'd3, 16'h0400, 16'h0000, 16'h0000);

        // trigger mode on an untouched voice, unused selector acts chromatic
        set_config(4'd15, 1'b1, 15'd4096, 10'd2);
        send_sample(4'd9, 16'h0500, 16'd0, 16'h0200);
        send_sample(4'd9, 16'h0500, 16'd4096, 16'h0000);
        send_sample(4'd9, 16'h0700, 16'd4097, 16'h0000);
        send_sample(4'd9, 16'h0900, 16'h7FFF, 16'h0000);
        send_sample(4'd9, 16'h0900, 16'd4096, 16'h0000);
        send_sample(4'd9, 16'h0900, 16'd4095, 16'h0000);
        send_sample(4'd9, 16'hF300, 16'd5000, 16'h0000);

        // back to free running on the same voice state
        set_config(4'd4, 1'b0, 15'd0, 10'd0);
        send_sample(4'd9, 16'hF300, 16'h0000, 16'h0000);
        send_sample(4'd9, 16'hF300, 16'h0000, 16'h0000);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_config(4'd0, 1'b1, 15'd0, 10'd0);
                1: set_config(4'd10, 1'b0, 15'h7FFF, 10'd1023);
                2: set_config(4'd15, 1'b1, 15'h7FFF, 10'd3);
                default: set_config(4'($urandom_range(15)), 1'($urandom_range(1)),
                                    ($urandom_range(1) == 1) ? 15'($urandom)
                                                             : 15'($urandom_range(4096)),
                                    ($urandom_range(1) == 1) ? 10'($urandom_range(4))
                                                             : 10'($urandom));
            endcase
            if (phase == 4) idle_on = 1'b0;
            if (phase == 6) begin
                // keep offering items while the output is held off
                idle_on = 1'b0;
                hold_off_req <= 1'b1;
            end
            repeat (PHASE_SAMPLES) send_random_sample();
            idle_on = 1'b1;
        end

        wait_drained();
        $display("covered %0d samples over %0d register settings in free and trigger modes,",
                 samples_sent, settings);
        $display("with a %0d-cycle output hold-off and a stretch without idle cycles",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
